FILE: rtl/dd_odo_pkg.sv
package dd_odo_pkg;

  // encoder counter width
  localparam int ENC_BITS = 16;

  typedef logic [ENC_BITS-1:0] enc_t;

  // register indexes, taken from paddr[2]
  localparam logic REG_MM_PER_TICK  = 1'b0;
  localparam logic REG_ANGLE_PER_MM = 1'b1;

  localparam logic [23:0] MM_PER_TICK_RST  = 24'd65536;
  localparam logic [23:0] ANGLE_PER_MM_RST = 24'd65536;

  // rotation unit
  localparam int CORDIC_ITERS = 16;
  localparam logic signed [32:0] CORDIC_START_X = 33'sd652032874;
  localparam logic signed [15:0] QUARTER_TURN   = 16'sd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_L,
    ST_MUL_R,
    ST_SUM,
    ST_TURN_LO,
    ST_TURN_HI,
    ST_ROTATE,
    ST_MUL_X,
    ST_MUL_Y,
    ST_DONE,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    MS_LEFT,
    MS_RIGHT,
    MS_TURN_LO,
    MS_TURN_HI,
    MS_SIN,
    MS_COS
  } mul_sel_t;

  // atan(2^-i) in units of 2^32 per turn
  function automatic logic [29:0] atan_units(input logic [3:0] i);
    logic [29:0] a;
    case (i)
      4'd0:    a = 30'd536870912;
      4'd1:    a = 30'd316933406;
      4'd2:    a = 30'd167458907;
      4'd3:    a = 30'd85004756;
      4'd4:    a = 30'd42667331;
      4'd5:    a = 30'd21354465;
      4'd6:    a = 30'd10680094;
      4'd7:    a = 30'd5340245;
      4'd8:    a = 30'd2670163;
      4'd9:    a = 30'd1335087;
      4'd10:   a = 30'd667544;
      4'd11:   a = 30'd333772;
      4'd12:   a = 30'd166886;
      4'd13:   a = 30'd83443;
      4'd14:   a = 30'd41721;
      4'd15:   a = 30'd20861;
      default: a = 30'd0;
    endcase
    return a;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [32:0] v);
    logic signed [15:0] r;
    if (v > 33'sd32767) r = 16'sh7fff;
    else if (v < -33'sd32768) r = 16'sh8000;
    else r = 16'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [40:0] v);
    logic signed [31:0] r;
    if (v > 41'sd2147483647) r = 32'sh7fffffff;
    else if (v < -41'sd2147483648) r = 32'sh80000000;
    else r = 32'(v);
    return r;
  endfunction

endpackage

FILE: rtl/differential_drive_odometry.sv
// channel   direction  handshake              payload
// input     in         in_valid / in_ready    left_count, right_count
// result    out        out_valid / out_ready  pos_x, pos_y, heading, left_delta, right_delta
// config    in         apb write / read       mm_per_tick (0x0), angle_per_mm (0x4)
//
// requests are not overlapped; the sequencer is busy from acceptance until it returns to idle:
// a 33x33 multiplier shared over six products plus a 16-step cordic loop
// the result sits in an output register, so a new request is taken while it waits;
// a stall at the output holds the sequencer in its final state until the register frees
// synchronous reset clears state, position, heading and counter history; no clearing pass
module differential_drive_odometry (
  input  logic               clk,
  input  logic               rst,
  // input requests
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [15:0] left_count,
  input  logic        [15:0] right_count,
  // results
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic        [15:0] heading,
  output logic signed [15:0] left_delta,
  output logic signed [15:0] right_delta,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic        [2:0]  paddr,
  input  logic        [31:0] pwdata,
  output logic        [31:0] prdata,
  output logic               pready
);

  dd_odo_pkg::state_t   state, state_next;
  dd_odo_pkg::mul_sel_t mul_sel;
  logic                 rot_en;
  logic                 out_load;
  logic                 accept;

  // configuration registers
  logic [23:0] mm_per_tick;
  logic [23:0] angle_per_mm;

  // architectural state
  dd_odo_pkg::enc_t   prev_left, prev_right;
  logic signed [31:0] acc_x, acc_y;
  logic        [15:0] acc_heading;

  // per-request working registers
  logic signed [15:0] dl, dr;
  logic signed [39:0] sl, sr;
  logic signed [31:0] ds;
  logic signed [32:0] ds_op;
  logic        [47:0] turn_lo;
  logic               flip;
  logic        [3:0]  iter;

  // cordic vector and residual angle
  logic signed [32:0] cx, cy;
  logic signed [33:0] cz;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] prod;

  // ---------------------------------------------------------------------------
  // apb port: always ready, address bit 2 picks the register
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_comb begin
    case (paddr[2])
      dd_odo_pkg::REG_MM_PER_TICK:  prdata = {8'h00, mm_per_tick};
      dd_odo_pkg::REG_ANGLE_PER_MM: prdata = {8'h00, angle_per_mm};
      default:                      prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mm_per_tick  <= dd_odo_pkg::MM_PER_TICK_RST;
      angle_per_mm <= dd_odo_pkg::ANGLE_PER_MM_RST;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        dd_odo_pkg::REG_MM_PER_TICK:  mm_per_tick  <= pwdata[23:0];
        dd_odo_pkg::REG_ANGLE_PER_MM: angle_per_mm <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      dd_odo_pkg::ST_IDLE:    if (in_valid) state_next = dd_odo_pkg::ST_MUL_L;
      dd_odo_pkg::ST_MUL_L:   state_next = dd_odo_pkg::ST_MUL_R;
      dd_odo_pkg::ST_MUL_R:   state_next = dd_odo_pkg::ST_SUM;
      dd_odo_pkg::ST_SUM:     state_next = dd_odo_pkg::ST_TURN_LO;
      dd_odo_pkg::ST_TURN_LO: state_next = dd_odo_pkg::ST_TURN_HI;
      dd_odo_pkg::ST_TURN_HI: state_next = dd_odo_pkg::ST_ROTATE;
      dd_odo_pkg::ST_ROTATE: begin
        if (iter == 4'(dd_odo_pkg::CORDIC_ITERS - 1)) state_next = dd_odo_pkg::ST_MUL_X;
      end
      dd_odo_pkg::ST_MUL_X:   state_next = dd_odo_pkg::ST_MUL_Y;
      dd_odo_pkg::ST_MUL_Y:   state_next = dd_odo_pkg::ST_DONE;
      dd_odo_pkg::ST_DONE:    state_next = dd_odo_pkg::ST_OUT;
      dd_odo_pkg::ST_OUT:     if (!out_valid || out_ready) state_next = dd_odo_pkg::ST_IDLE;
      default:                state_next = dd_odo_pkg::ST_IDLE;
    endcase
  end

  // control decode
  always_comb begin
    in_ready = 1'b0;
    rot_en   = 1'b0;
    out_load = 1'b0;
    mul_sel  = dd_odo_pkg::MS_LEFT;
    case (state)
      dd_odo_pkg::ST_IDLE:    in_ready = 1'b1;
      dd_odo_pkg::ST_MUL_L:   mul_sel  = dd_odo_pkg::MS_LEFT;
      dd_odo_pkg::ST_MUL_R:   mul_sel  = dd_odo_pkg::MS_RIGHT;
      dd_odo_pkg::ST_TURN_LO: mul_sel  = dd_odo_pkg::MS_TURN_LO;
      dd_odo_pkg::ST_TURN_HI: mul_sel  = dd_odo_pkg::MS_TURN_HI;
      dd_odo_pkg::ST_ROTATE:  rot_en   = 1'b1;
      dd_odo_pkg::ST_MUL_X:   mul_sel  = dd_odo_pkg::MS_SIN;
      dd_odo_pkg::ST_MUL_Y:   mul_sel  = dd_odo_pkg::MS_COS;
      dd_odo_pkg::ST_OUT:     out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= dd_odo_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // ---------------------------------------------------------------------------
  // tick deltas: wrapped difference read as signed, then held to 16 bits
  // ---------------------------------------------------------------------------
  dd_odo_pkg::enc_t cur_left, cur_right, diff_left, diff_right;

  assign cur_left   = dd_odo_pkg::enc_t'(left_count);
  assign cur_right  = dd_odo_pkg::enc_t'(right_count);
  assign diff_left  = cur_left - prev_left;
  assign diff_right = cur_right - prev_right;

  // heading folded into +-quarter turn; for the far half the travel is negated afterwards
  logic signed [15:0] hs, hs_red;
  logic               hs_far;

  assign hs     = $signed(acc_heading);
  assign hs_far = (hs > dd_odo_pkg::QUARTER_TURN) || (hs < -dd_odo_pkg::QUARTER_TURN);
  assign hs_red = hs_far ? (hs ^ 16'sh8000) : hs;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
    end else if (accept) begin
      prev_left  <= cur_left;
      prev_right <= cur_right;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      dl   <= dd_odo_pkg::sat16(33'($signed(diff_left)));
      dr   <= dd_odo_pkg::sat16(33'($signed(diff_right)));
      flip <= hs_far;
    end
  end

  // ---------------------------------------------------------------------------
  // shared multiplier, product registered before use
  // ---------------------------------------------------------------------------
  logic signed [47:0] turn_arg;
  logic        [47:0] turn_sum;
  logic signed [40:0] travel_sum;

  // right minus left travel, modulo 2^48 is all the heading needs
  assign turn_arg   = 48'(sr) - 48'(sl);
  assign travel_sum = 41'(sl) + 41'(sr);
  assign turn_sum   = turn_lo + {prod[23:0], 24'h0};

  always_comb begin
    case (mul_sel)
      dd_odo_pkg::MS_LEFT: begin
        mul_a = 33'(dl);
        mul_b = $signed({9'h0, mm_per_tick});
      end
      dd_odo_pkg::MS_RIGHT: begin
        mul_a = 33'(dr);
        mul_b = $signed({9'h0, mm_per_tick});
      end
      dd_odo_pkg::MS_TURN_LO: begin
        mul_a = $signed({9'h0, turn_arg[23:0]});
        mul_b = $signed({9'h0, angle_per_mm});
      end
      dd_odo_pkg::MS_TURN_HI: begin
        mul_a = $signed({9'h0, turn_arg[47:24]});
        mul_b = $signed({9'h0, angle_per_mm});
      end
      dd_odo_pkg::MS_SIN: begin
        mul_a = ds_op;
        mul_b = cy;
      end
      dd_odo_pkg::MS_COS: begin
        mul_a = ds_op;
        mul_b = cx;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_p;
  end

  // each product is taken up in the state after the one that issues it
  always_ff @(posedge clk) begin
    case (state)
      dd_odo_pkg::ST_MUL_R:   sl <= prod[39:0];
      dd_odo_pkg::ST_SUM:     sr <= prod[39:0];
      // mean travel, floored, held to 32 bits
      dd_odo_pkg::ST_TURN_LO: ds <= dd_odo_pkg::sat32(41'($signed(travel_sum[40:1])));
      dd_odo_pkg::ST_TURN_HI: turn_lo <= prod[47:0];
      default: ;
    endcase
    // far half: negate the travel instead of the sine and cosine
    if (rot_en && iter == 4'd0) ds_op <= flip ? -33'(ds) : 33'(ds);
  end

  // ---------------------------------------------------------------------------
  // pose accumulators
  // ---------------------------------------------------------------------------
  logic signed [40:0] step_sum_x, step_sum_y;

  assign step_sum_x = 41'(acc_x) + 41'($signed(prod[65:30]));
  assign step_sum_y = 41'(acc_y) + 41'($signed(prod[65:30]));

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_x       <= '0;
      acc_y       <= '0;
      acc_heading <= '0;
    end else begin
      // heading moves by the upper turn bits once both halves are in
      if (rot_en && iter == 4'd0) acc_heading <= acc_heading + turn_sum[47:32];
      if (state == dd_odo_pkg::ST_MUL_Y) acc_x <= dd_odo_pkg::sat32(step_sum_x);
      if (state == dd_odo_pkg::ST_DONE)  acc_y <= dd_odo_pkg::sat32(step_sum_y);
    end
  end

  // ---------------------------------------------------------------------------
  // cordic rotation, one micro-rotation a cycle; set up at acceptance from
  // the heading as it was before this request
  // ---------------------------------------------------------------------------
  logic signed [32:0] cx_sh, cy_sh;
  logic signed [33:0] atan_step;

  assign cx_sh     = cx >>> iter;
  assign cy_sh     = cy >>> iter;
  assign atan_step = $signed(34'(dd_odo_pkg::atan_units(iter)));

  always_ff @(posedge clk) begin
    if (accept) begin
      cx <= dd_odo_pkg::CORDIC_START_X;
      cy <= '0;
      cz <= 34'($signed({hs_red, 16'h0}));
    end else if (rot_en) begin
      if (cz >= 0) begin
        cx <= cx - cy_sh;
        cy <= cy + cx_sh;
        cz <= cz - atan_step;
      end else begin
        cx <= cx + cy_sh;
        cy <= cy - cx_sh;
        cz <= cz + atan_step;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst)         iter <= '0;
    else if (accept) iter <= '0;
    else if (rot_en) iter <= iter + 4'd1;
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      pos_x       <= acc_x;
      pos_y       <= acc_y;
      heading     <= acc_heading;
      left_delta  <= dl;
      right_delta <= dr;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while a request is in flight");

  a_rotate_length: assert property (@(posedge clk) disable iff (rst)
    (state == dd_odo_pkg::ST_ROTATE && iter == 4'(dd_odo_pkg::CORDIC_ITERS - 1))
      |=> state == dd_odo_pkg::ST_MUL_X)
    else $error("rotation loop did not end after its last step");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == dd_odo_pkg::ST_OUT)
    else $error("result shown outside the final state");

  a_heading_update: assert property (@(posedge clk) disable iff (rst)
    !$stable(acc_heading) |-> ($past(rst) || $past(state) == dd_odo_pkg::ST_ROTATE))
    else $error("heading changed outside its update step");

  a_prev_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(accept) && !$past(rst) |-> $stable(prev_left) && $stable(prev_right))
    else $error("counter history changed without a request");

endmodule

FILE: tb/odometry_check_pkg.sv
package odometry_check_pkg;

  import dd_odo_pkg::*;

  typedef struct {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [15:0] heading;
    logic signed [15:0] left_delta;
    logic signed [15:0] right_delta;
  } pose_t;

  // atan(2^-i), 2^32 units per turn
  localparam longint ROT_ANGLE [16] = '{
    536870912, 316933406, 167458907, 85004756,
    42667331, 21354465, 10680094, 5340245,
    2670163, 1335087, 667544, 333772,
    166886, 83443, 41721, 20861
  };

  localparam longint POS_MAX = 64'sh7fff_ffff;
  localparam longint POS_MIN = -64'sh8000_0000;

  class odometry_scoreboard;
    logic        [23:0] mm_per_tick;
    logic        [23:0] angle_per_mm;
    enc_t               last_left;
    enc_t               last_right;
    logic signed [31:0] x_acc;
    logic signed [31:0] y_acc;
    logic        [15:0] heading_acc;
    pose_t              awaited[$];
    int                 failures;

    function new();
      mm_per_tick  = MM_PER_TICK_RST;
      angle_per_mm = ANGLE_PER_MM_RST;
      last_left    = '0;
      last_right   = '0;
      x_acc        = '0;
      y_acc        = '0;
      heading_acc  = '0;
      failures     = 0;
    endfunction

    function void set_reg(input logic idx, input logic [23:0] v);
      if (idx == REG_MM_PER_TICK) mm_per_tick = v;
      else angle_per_mm = v;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // count the mismatch and log it with the time
    function void flag(input string what);
      failures++;
      $display("%0t: %s", $time, what);
    endfunction

    function longint clamp_pos(input longint v);
      if (v > POS_MAX) return POS_MAX;
      if (v < POS_MIN) return POS_MIN;
      return v;
    endfunction

    // wrapped counter difference, saturated to 16 bits signed
    function longint wheel_ticks(input logic [15:0] now, inout enc_t prev);
      enc_t   d;
      longint s;
      d    = enc_t'(now) - prev;
      prev = enc_t'(now);
      s    = longint'(d);
      if (d[ENC_BITS-1]) s -= longint'(1) << ENC_BITS;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      return s;
    endfunction

    // iterative rotation, outer half turns folded in and the sign restored after
    function void rotate(input logic [15:0] ang, output longint sn, output longint cs);
      longint s, x, y, z, xs, ys;
      bit     flip;
      s    = longint'($signed(ang));
      flip = 1'b0;
      if (s > QUARTER_TURN || s < -QUARTER_TURN) begin
        s    = (s >= 0) ? s - 32768 : s + 32768;
        flip = 1'b1;
      end
      z = s * 65536;
      x = CORDIC_START_X;
      y = 0;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys;
          y += xs;
          z -= ROT_ANGLE[i];
        end else begin
          x += ys;
          y -= xs;
          z += ROT_ANGLE[i];
        end
      end
      if (flip) begin
        x = -x;
        y = -y;
      end
      sn = y;
      cs = x;
    endfunction

    function void note_request(input logic [15:0] l, input logic [15:0] r);
      longint      dl, dr, sl, sr, ds, sn, cs;
      logic [63:0] turn;
      pose_t       p;
      dl = wheel_ticks(l, last_left);
      dr = wheel_ticks(r, last_right);
      sl = dl * longint'(mm_per_tick);
      sr = dr * longint'(mm_per_tick);
      ds = clamp_pos((sl + sr) >>> 1);
      rotate(heading_acc, sn, cs);
      x_acc = 32'(clamp_pos(longint'(x_acc) + ((ds * sn) >>> 30)));
      y_acc = 32'(clamp_pos(longint'(y_acc) + ((ds * cs) >>> 30)));
      turn        = 64'(sr - sl) * 64'(angle_per_mm);
      heading_acc = heading_acc + turn[47:32];
      p.pos_x       = x_acc;
      p.pos_y       = y_acc;
      p.heading     = heading_acc;
      p.left_delta  = 16'(dl);
      p.right_delta = 16'(dr);
      awaited.push_back(p);
    endfunction

    function void compare(input string name, input logic signed [31:0] want,
                          input logic signed [31:0] got);
      if (got !== want) flag($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function void check_result(input pose_t got);
      pose_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("unexpected result x %0d y %0d heading %0d",
                       got.pos_x, got.pos_y, got.heading));
        return;
      end
      want = awaited.pop_front();
      compare("pos_x", want.pos_x, got.pos_x);
      compare("pos_y", want.pos_y, got.pos_y);
      compare("heading", want.heading, got.heading);
      compare("left_delta", want.left_delta, got.left_delta);
      compare("right_delta", want.right_delta, got.right_delta);
    endfunction
  endclass

endpackage

FILE: tb/testbench.sv
module testbench;

  import dd_odo_pkg::*;
  import odometry_check_pkg::*;

  // limit for the whole run, well above what the slowest honest run needs
  localparam int CYCLE_LIMIT     = 400000;
  localparam int ITEMS_PER_PHASE = 220;
  // settle wait, longer than a request occupies the sequencer
  localparam int SETTLE_CYCLES   = 40;
  localparam int LONG_HOLD       = 300;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_ready;
  logic        [15:0] left_count;
  logic        [15:0] right_count;
  logic               out_valid;
  logic               out_ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [15:0] heading;
  logic signed [15:0] left_delta;
  logic signed [15:0] right_delta;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic        [2:0]  paddr;
  logic        [31:0] pwdata;
  logic        [31:0] prdata;
  logic               pready;

  odometry_scoreboard sb = new();

  // pacing knobs: percentage of cycles each side sits idle
  int          send_idle_pct;
  int          recv_idle_pct;
  logic        long_hold_armed;
  int          cycle_count;
  logic [15:0] last_left_sent;
  logic [15:0] last_right_sent;

  differential_drive_odometry dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .left_count  (left_count),
    .right_count (right_count),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .heading     (heading),
    .left_delta  (left_delta),
    .right_delta (right_delta),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // watchdog: a hung handshake or a lost result ends up here
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("differential_drive_odometry verification failed");
    $finish;
  end

  // result side: sample at the edge, then choose ready for the next cycle.
  // the long hold-off is counted here so the sender keeps pushing meanwhile
  initial begin : result_sink
    pose_t seen;
    int    hold_left;
    bit    hold_done;
    out_ready = 1'b0;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        seen = '{pos_x, pos_y, heading, left_delta, right_delta};
        sb.check_result(seen);
      end
      if (long_hold_armed && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // offer one request; valid is only dropped when a gap is taken, so a
  // back-to-back request keeps valid high without a gap
  task automatic send_request(input logic [15:0] l, input logic [15:0] r);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < send_idle_pct) @(posedge clk);
    end
    in_valid    <= 1'b1;
    left_count  <= l;
    right_count <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(l, r);
    last_left_sent  = l;
    last_right_sent = r;
  endtask

  // move each wheel by a given tick count from the last sample
  task automatic nudge(input logic [15:0] dl, input logic [15:0] dr);
    send_request(last_left_sent + dl, last_right_sent + dr);
  endtask

  // stop offering and wait until every predicted result has been seen
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // apb write followed by a read-back of the same register
  task automatic reg_write_check(input logic idx, input logic [23:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    // register taken at that edge; go straight into the read setup
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(v))
      sb.flag($sformatf("register %0d read expected %0d got %0d", idx, v, prdata));
    psel    <= 1'b0;
    penable <= 1'b0;
    // leave the bus idle before the next transfer
    @(posedge clk);
    sb.set_reg(idx, v);
  endtask

  // only touched with the block idle: drained and past its own latency
  task automatic configure(input logic [23:0] mm, input logic [23:0] ang);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    reg_write_check(REG_MM_PER_TICK, mm);
    reg_write_check(REG_ANGLE_PER_MM, ang);
  endtask

  task automatic set_pace(input int sender_pct, input int receiver_pct);
    send_idle_pct = sender_pct;
    recv_idle_pct <= receiver_pct;
  endtask

  // mostly plausible driving: small correlated wheel steps, with full random
  // counter jumps, extreme half-range steps and standstill mixed in
  task automatic pick_counts(output logic [15:0] l, output logic [15:0] r);
    int                 sel;
    int                 k;
    logic signed [15:0] step_l;
    logic signed [15:0] twist;
    sel = $urandom_range(0, 99);
    k   = $urandom_range(0, 14);
    if (sel < 70) begin
      step_l = 16'($urandom);
      step_l = step_l >>> (15 - k);
      twist  = 16'($urandom);
      twist  = twist >>> $urandom_range(6, 14);
      l = last_left_sent + step_l;
      r = last_right_sent + step_l + twist;
    end else if (sel < 85) begin
      l = 16'($urandom);
      r = 16'($urandom);
    end else if (sel < 95) begin
      l = last_left_sent + ($urandom_range(0, 1) ? 16'h7fff : 16'h8000);
      case ($urandom_range(0, 2))
        0:       r = last_right_sent + 16'h7fff;
        1:       r = last_right_sent + 16'h8000;
        default: r = last_right_sent;
      endcase
    end else begin
      l = last_left_sent;
      r = last_right_sent;
    end
  endtask

  task automatic run_phase(input logic [23:0] mm, input logic [23:0] ang,
                           input int pause_at, input int hold_at);
    logic [15:0] l;
    logic [15:0] r;
    configure(mm, ang);
    for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
      // sender waits for the block to empty completely
      if (i == pause_at) drain();
      if (i == hold_at) long_hold_armed <= 1'b1;
      pick_counts(l, r);
      send_request(l, r);
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    left_count      = '0;
    right_count     = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    send_idle_pct   = 28;
    recv_idle_pct   = 85;
    long_hold_armed = 1'b0;
    last_left_sent  = '0;
    last_right_sent = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset scales: one tick is one mm, one mm of difference one angle unit
    send_request(16'h0000, 16'h0000);
    send_request(16'h0001, 16'h0001);
    send_request(16'h0000, 16'h0000);
    // counters wrapping through zero in both directions
    send_request(16'hffff, 16'h0001);
    send_request(16'h0000, 16'hffff);
    // largest forward and backward deltas
    send_request(16'h7fff, 16'h7fff);
    send_request(16'hffff, 16'hffff);
    send_request(16'h7ffe, 16'h7ffe);

    // full-scale registers: travel saturates, position pins at its limit
    configure(24'hffffff, 24'hffffff);
    nudge(16'h7fff, 16'h7fff);
    nudge(16'h7fff, 16'h7fff);
    nudge(16'h7fff, 16'h7fff);
    // half-range spin wraps the heading, then full reverse
    nudge(16'h8000, 16'h0000);
    nudge(16'h8000, 16'h8000);
    nudge(16'h8000, 16'h8000);

    // zero scales: counters move, pose must not
    configure(24'd0, 24'd0);
    send_request(16'h1234, 16'habcd);
    send_request(16'hedcb, 16'h5432);

    // roughly quarter turns while driving, to visit every quadrant
    configure(24'd65536, 24'hffffff);
    nudge(16'd100, 16'd164);
    nudge(16'd100, 16'd164);
    nudge(16'd100, 16'd164);
    nudge(16'd100, 16'd164);
    nudge(16'd200, 16'd200);

    // random driving under several register settings
    run_phase(24'd65536, 24'd65536, -1, -1);
    run_phase(24'($urandom_range(4096, 262144)), 24'($urandom), 110, -1);
    set_pace(85, 28);
    run_phase(24'hffffff, 24'hffffff, -1, -1);
    run_phase(24'd0, 24'($urandom), -1, -1);
    set_pace(0, 0);
    run_phase(24'($urandom), 24'd0, -1, -1);
    run_phase(24'($urandom_range(0, 1 << 20)), 24'($urandom_range(0, 1 << 20)), -1, 60);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures == 0)
      $display("differential_drive_odometry verification clean");
    else
      $display("differential_drive_odometry verification failed");
    $finish;
  end

endmodule
